[rtl/rilp_pkg.sv]
`timescale 1ns / 1ps

package rilp_pkg;

    localparam int VALUE_W = 31;
    localparam int ACC_EXT_W = 36;

    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;

    localparam logic [2:0] KIND_PLAIN_DEC = 3'd0;
    localparam logic [2:0] KIND_BIN = 3'd1;
    localparam logic [2:0] KIND_OCT = 3'd2;
    localparam logic [2:0] KIND_PREFIX_DEC = 3'd3;
    localparam logic [2:0] KIND_HEX = 3'd4;

    localparam logic [4:0] DEC_RADIX = 5'd10;

    localparam logic [ACC_EXT_W-1:0] VALUE_MAX = ACC_EXT_W'(32'h7FFF_FFFF);

    // one accepted input item
    typedef struct packed {
        logic [7:0] char_code;
        logic [2:0] kind;
        logic       last;
    } item_t;

    // per-literal parse state
    typedef struct packed {
        logic [VALUE_W-1:0] acc;
        logic [1:0]         pos;
        logic               err;
    } parse_state_t;

endpackage

[rtl/rilp_step.sv]
`timescale 1ns / 1ps

module rilp_step
(
    input  rilp_pkg::item_t        item,
    input  rilp_pkg::parse_state_t state_cur,
    output rilp_pkg::parse_state_t state_new
);

    logic [4:0]                        radix;
    logic                              prefixed;
    logic [4:0]                        digit;
    logic                              is_digit;
    logic                              use_char;
    logic [rilp_pkg::ACC_EXT_W-1:0]    acc_ext;
    logic [rilp_pkg::ACC_EXT_W-1:0]    scaled;
    logic [rilp_pkg::ACC_EXT_W-1:0]    sum;

    always_comb
    begin
        case (item.kind)
            rilp_pkg::KIND_BIN: radix = 5'd2;
            rilp_pkg::KIND_OCT: radix = 5'd8;
            rilp_pkg::KIND_HEX: radix = 5'd16;
            default:            radix = rilp_pkg::DEC_RADIX;
        endcase
    end

    assign prefixed = (item.kind >= rilp_pkg::KIND_BIN) && (item.kind <= rilp_pkg::KIND_HEX);

    // digit decode, letters only count in hex
    always_comb
    begin
        digit = 5'd0;
        is_digit = 1'b0;
        if (item.char_code >= rilp_pkg::CHAR_ZERO && item.char_code <= rilp_pkg::CHAR_NINE)
        begin
            digit = 5'(item.char_code - rilp_pkg::CHAR_ZERO);
            is_digit = 1'b1;
        end
        else if (item.kind == rilp_pkg::KIND_HEX && item.char_code >= rilp_pkg::CHAR_LOWER_A
                 && item.char_code <= rilp_pkg::CHAR_LOWER_F)
        begin
            digit = 5'(item.char_code - rilp_pkg::CHAR_LOWER_A) + 5'd10;
            is_digit = 1'b1;
        end
        else if (item.kind == rilp_pkg::KIND_HEX && item.char_code >= rilp_pkg::CHAR_UPPER_A
                 && item.char_code <= rilp_pkg::CHAR_UPPER_F)
        begin
            digit = 5'(item.char_code - rilp_pkg::CHAR_UPPER_A) + 5'd10;
            is_digit = 1'b1;
        end
        if (digit >= radix)
        begin
            is_digit = 1'b0;
        end
    end

    // radix multiply as shifts, times ten is times eight plus times two
    assign acc_ext = rilp_pkg::ACC_EXT_W'(state_cur.acc);

    always_comb
    begin
        case (item.kind)
            rilp_pkg::KIND_BIN: scaled = acc_ext << 1;
            rilp_pkg::KIND_OCT: scaled = acc_ext << 3;
            rilp_pkg::KIND_HEX: scaled = acc_ext << 4;
            default:            scaled = (acc_ext << 3) + (acc_ext << 1);
        endcase
    end

    assign sum = scaled + rilp_pkg::ACC_EXT_W'(digit);

    assign use_char = !(prefixed && state_cur.pos < 2'd2)
                      && (item.char_code != rilp_pkg::CHAR_UNDERSCORE)
                      && !state_cur.err && is_digit;

    always_comb
    begin
        state_new = state_cur;
        if (state_cur.pos < 2'd2)
        begin
            state_new.pos = state_cur.pos + 2'd1;
        end
        if (use_char)
        begin
            if (sum > rilp_pkg::VALUE_MAX)
            begin
                state_new.err = 1'b1;
            end
            else
            begin
                state_new.acc = sum[rilp_pkg::VALUE_W-1:0];
            end
        end
    end

endmodule

[rtl/radix_integer_literal_parser_core.sv]
`timescale 1ns / 1ps

// radix integer literal parser
//
// item channel: item_valid / item_stall carry one character of a literal per item,
// with its radix kind and a last marker. prefixed kinds skip their first two
// characters; underscores and characters that are not digits of the radix are skipped
// result channel: result_valid / result_stall carry one result per literal, sent for
// the item marked last: the value, or zero with overflow set if the value ever went
// past the int32 maximum
//
// an item goes into an input register, the digit step (shift-add multiply by the
// radix, add, compare) runs combinationally from there into the state and result
// registers. a result turns valid in the result register as its last item leaves
// the input register. throughput is one item per cycle, held only when a last
// item finds the result register full and stalled; other items still flow then
//
// reset clears the parse state and both valid flags. while result_stall is high the
// result holds steady; item_stall rises only when the input register cannot move

module radix_integer_literal_parser_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [7:0]                    char_code,
    input  logic [2:0]                    kind,
    input  logic                          last,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [rilp_pkg::VALUE_W-1:0]  value,
    output logic                          overflow
);

    // input register
    logic                   in_vld_reg;
    logic                   in_vld_next;
    rilp_pkg::item_t        in_item_reg;

    // parse state
    rilp_pkg::parse_state_t state_reg;
    rilp_pkg::parse_state_t state_next;
    rilp_pkg::parse_state_t state_step;

    // result register
    logic                   out_vld_reg;
    logic                   out_vld_next;
    logic [rilp_pkg::VALUE_W-1:0] value_reg;
    logic                   overflow_reg;

    logic                   out_free;
    logic                   advance;
    logic                   take_in;

    rilp_step u_step
    (
        .item      (in_item_reg),
        .state_cur (state_reg),
        .state_new (state_step)
    );

    // result slot frees when empty or being taken this edge
    assign out_free = !out_vld_reg || !result_stall;
    // only a last item needs the result slot
    assign advance = in_vld_reg && (!in_item_reg.last || out_free);
    assign item_stall = in_vld_reg && !advance;
    assign take_in = item_valid && !item_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (take_in)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (advance)
        begin
            if (in_item_reg.last)
            begin
                // literal done, back to reset state
                state_next = '0;
            end
            else
            begin
                state_next = state_step;
            end
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (advance && in_item_reg.last)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_vld_reg && !result_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            state_reg   <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_item_reg.char_code <= char_code;
            in_item_reg.kind      <= kind;
            in_item_reg.last      <= last;
        end
        if (advance && in_item_reg.last)
        begin
            value_reg    <= state_step.err ? '0 : state_step.acc;
            overflow_reg <= state_step.err;
        end
    end

    assign result_valid = out_vld_reg;
    assign value        = value_reg;
    assign overflow     = overflow_reg;

endmodule

[bench/tb_radix_integer_literal_parser_core.sv]
`timescale 1ns / 1ps

module tb_radix_integer_literal_parser_core;

    import rilp_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 11;
    localparam int ITEM_TARGET     = 1350;
    localparam int IDLE_PCT        = 19;
    localparam int CALM_ITEMS      = 350;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 20;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int REPORT_MAX      = 10;

    // kinds outside the defined set, parsed as plain decimal
    localparam logic [2:0] KIND_RESERVED_5 = 3'd5;
    localparam logic [2:0] KIND_RESERVED_7 = 3'd7;

    // one literal result as the block should report it
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               overflow;
    } literal_result_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // item channel, known from time zero
    logic       item_valid = 1'b0;
    logic       item_stall;
    logic [7:0] char_code  = 8'h00;
    logic [2:0] kind       = KIND_PLAIN_DEC;
    logic       last       = 1'b0;

    // result channel
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [VALUE_W-1:0] value;
    logic               overflow;

    // predicted parse state of the literal in flight
    logic [VALUE_W-1:0] lit_acc;
    logic [1:0]         lit_pos;
    logic               lit_err;

    // results still owed by the block, oldest first
    literal_result_t pending_literals[$];

    // characters of the literal being built by a test
    logic [7:0] lit_buf[$];

    int  items_sent   = 0;
    int  fail_count   = 0;
    int  report_count = 0;
    int  cycle_count  = 0;
    int  hold_cycles  = 0;
    // set to run both sides without idling
    bit  no_idle      = 1'b0;

    radix_integer_literal_parser_core u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .char_code    (char_code),
        .kind         (kind),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value        (value),
        .overflow     (overflow)
    );

    // 10 ns clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // radix for a kind, undefined kinds fall back to decimal
    function automatic int radix_of(input logic [2:0] k);
        case (k)
            KIND_BIN: return 2;
            KIND_OCT: return 8;
            KIND_HEX: return 16;
            default:  return int'(DEC_RADIX);
        endcase
    endfunction

    // advance the predicted parse by one accepted character
    task automatic predict_char(input logic [7:0] ch, input logic [2:0] k, input logic l);
        int              radix;
        logic            prefixed;
        logic            is_digit;
        int              digit;
        logic [63:0]     next_acc;
        literal_result_t res;
        begin
            radix    = radix_of(k);
            prefixed = (k >= KIND_BIN) && (k <= KIND_HEX);
            is_digit = 1'b1;
            digit    = 0;
            if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
                digit = int'(ch - CHAR_ZERO);
            else if (radix == 16 && ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_F)
                digit = int'(ch - CHAR_LOWER_A) + 10;
            else if (radix == 16 && ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_F)
                digit = int'(ch - CHAR_UPPER_A) + 10;
            else
                is_digit = 1'b0;
            if (digit >= radix)
                is_digit = 1'b0;

            // prefix characters, separators and junk leave the value alone
            if (!(prefixed && lit_pos < 2'd2) && ch != CHAR_UNDERSCORE && !lit_err && is_digit)
            begin
                next_acc = 64'(lit_acc) * 64'(radix) + 64'(digit);
                if (next_acc > 64'(VALUE_MAX))
                    lit_err = 1'b1;     // sticky, value frozen from here on
                else
                    lit_acc = next_acc[VALUE_W-1:0];
            end
            if (lit_pos < 2'd2)
                lit_pos = lit_pos + 2'd1;

            if (l)
            begin
                res.value    = lit_err ? '0 : lit_acc;
                res.overflow = lit_err;
                pending_literals.push_back(res);
                lit_acc = '0;
                lit_pos = '0;
                lit_err = 1'b0;
            end
        end
    endtask

    // offer one item, with random idle cycles ahead of it, until it is taken
    task automatic send_item(input logic [7:0] ch, input logic [2:0] k, input logic l);
        begin
            while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
            item_valid <= 1'b1;
            char_code  <= ch;
            kind       <= k;
            last       <= l;
            @(posedge clk);
            while (item_stall !== 1'b0)
                @(posedge clk);
            items_sent = items_sent + 1;
            predict_char(ch, k, l);
        end
    endtask

    // send the built literal, last marker on its final character
    task automatic send_buffer(input logic [2:0] k);
        int i;
        begin
            for (i = 0; i < lit_buf.size(); i++)
                send_item(lit_buf[i], k, i == lit_buf.size() - 1);
        end
    endtask

    task automatic load_text(input string text);
        int i;
        begin
            lit_buf = {};
            for (i = 0; i < text.len(); i++)
                lit_buf.push_back(text[i]);
        end
    endtask

    // drop valid and wait for every owed result
    task automatic wait_results_drained();
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while (pending_literals.size() != 0);
        end
    endtask

    // a well-formed literal of random kind and digits
    task automatic build_random_literal(output logic [2:0] k);
        int   radix;
        int   max_len;
        int   n;
        int   i;
        int   d;
        logic prefixed;
        begin
            k        = 3'($urandom_range(0, 7));
            radix    = radix_of(k);
            prefixed = (k >= KIND_BIN) && (k <= KIND_HEX);
            lit_buf  = {};
            if (prefixed)
            begin
                // the prefix is skipped whatever it holds
                lit_buf.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : CHAR_ZERO);
                if ($urandom_range(0, 9) == 0)
                    lit_buf.push_back(8'($urandom));
                else
                    case (k)
                        KIND_BIN: lit_buf.push_back("b");
                        KIND_OCT: lit_buf.push_back("o");
                        KIND_PREFIX_DEC: lit_buf.push_back("d");
                        default: lit_buf.push_back("x");
                    endcase
            end
            // digit counts that reach past the int32 maximum
            case (radix)
                2:       max_len = 33;
                8:       max_len = 12;
                16:      max_len = 9;
                default: max_len = 11;
            endcase
            if ($urandom_range(0, 3) == 0)
                n = $urandom_range(max_len - 3, max_len);
            else
                n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    lit_buf.push_back(CHAR_UNDERSCORE);
                d = $urandom_range(0, radix - 1);
                if (d < 10)
                    lit_buf.push_back(CHAR_ZERO + 8'(d));
                else if ($urandom_range(0, 1) == 1)
                    lit_buf.push_back(CHAR_UPPER_A + 8'(d - 10));
                else
                    lit_buf.push_back(CHAR_LOWER_A + 8'(d - 10));
            end
        end
    endtask

    // receiver: check each taken result, then pick the next stall
    always @(posedge clk)
    begin
        literal_result_t want;
        if (rst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (pending_literals.size() == 0)
            begin
                fail_count = fail_count + 1;
                if (report_count < REPORT_MAX)
                    $display("unexpected result: value %0d overflow %0b", value, overflow);
                report_count = report_count + 1;
            end
            else
            begin
                want = pending_literals.pop_front();
                if (value !== want.value || overflow !== want.overflow)
                begin
                    fail_count = fail_count + 1;
                    if (report_count < REPORT_MAX)
                        $display("mismatch: expected value %0d overflow %0b, got value %0d overflow %0b",
                                 want.value, want.overflow, value, overflow);
                    report_count = report_count + 1;
                end
            end
        end
        // long hold-off first, otherwise random stalls
        if (hold_cycles > 0)
        begin
            result_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end
        else
            result_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // boundaries, every kind and the odd cases
    task automatic test_directed();
        begin
            // one past the maximum on the final digit, reserved kind parses as decimal
            load_text("2147483648");
            send_buffer(KIND_RESERVED_7);
            // hex maximum, both letter cases
            load_text("0x7fFFffFF");
            send_buffer(KIND_HEX);
            // literal ends inside its prefix
            load_text("0x");
            send_buffer(KIND_HEX);
            // kind changes mid-literal: binary then a hex digit
            send_item(CHAR_ZERO, KIND_BIN, 1'b0);
            send_item("b", KIND_BIN, 1'b0);
            send_item("1", KIND_BIN, 1'b0);
            send_item("f", KIND_HEX, 1'b1);
            // lone byte that is no digit
            send_item(8'hFF, KIND_PLAIN_DEC, 1'b1);
            // octal with an invalid digit ignored
            load_text("0o78");
            send_buffer(KIND_OCT);
            // prefixed decimal with a separator
            load_text("0d_5");
            send_buffer(KIND_PREFIX_DEC);
            send_item(CHAR_UNDERSCORE, KIND_RESERVED_5, 1'b1);
            wait_results_drained();
        end
    endtask

    // receiver holds off while short literals keep coming, so the block stalls its input
    task automatic test_result_hold_off();
        int       i;
        logic [2:0] k;
        begin
            hold_cycles = HOLD_OFF_CYCLES;
            for (i = 0; i < 40; i++)
            begin
                k = 3'($urandom_range(0, 7));
                send_item(CHAR_ZERO + 8'($urandom_range(0, 9)), k,
                          1'($urandom_range(0, 1)));
            end
            send_item(CHAR_ZERO, KIND_PLAIN_DEC, 1'b1);
            wait_results_drained();
        end
    endtask

    // sender pauses for every result between literals
    task automatic test_paused_literals();
        int       i;
        logic [2:0] k;
        begin
            for (i = 0; i < 6; i++)
            begin
                build_random_literal(k);
                send_buffer(k);
                wait_results_drained();
            end
        end
    endtask

    // mostly well-formed literals, the rest noise and broken ones
    task automatic test_random_literals();
        int         i;
        int         n;
        int         pick;
        logic [2:0] k;
        begin
            no_idle = 1'b1;
            while (items_sent < ITEM_TARGET)
            begin
                if (items_sent >= CALM_ITEMS)
                    no_idle = 1'b0;
                pick = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    build_random_literal(k);
                    send_buffer(k);
                end
                else if (pick < 88)
                begin
                    // ends inside the prefix
                    k = 3'($urandom_range(int'(KIND_BIN), int'(KIND_HEX)));
                    if ($urandom_range(0, 1) == 1)
                        send_item(CHAR_ZERO, k, 1'b0);
                    send_item(8'($urandom), k, 1'b1);
                end
                else
                begin
                    // random bytes and kinds, last at random
                    n = $urandom_range(1, 6);
                    for (i = 0; i < n; i++)
                        send_item(8'($urandom), 3'($urandom_range(0, 7)),
                                  (i == n - 1) || ($urandom_range(0, 7) == 0));
                end
            end
        end
    endtask

    initial
    begin
        lit_acc = '0;
        lit_pos = '0;
        lit_err = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_result_hold_off();
        test_paused_literals();
        test_random_literals();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_literals.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
rtl/rilp_pkg.sv
rtl/rilp_step.sv
rtl/radix_integer_literal_parser_core.sv
bench/tb_radix_integer_literal_parser_core.sv
